FILE: rtl/text_scrollback_line_ring_defines.svh
// Assertion macros for the scrollback ring RTL.
// Each macro expands to one labeled concurrent assertion, or to nothing when
// SYNTH is defined.
`ifndef TEXT_SCROLLBACK_LINE_RING_DEFINES_SVH
`define TEXT_SCROLLBACK_LINE_RING_DEFINES_SVH

`ifndef SYNTH
`define TSR_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("scrollback ring assertion failed");
`define TSR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("scrollback ring assertion failed");
`else
`define TSR_ASSERT_SAME(label, clk, rstn, ante, cons)
`define TSR_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

FILE: rtl/tsr_pkg.sv
package tsr_pkg;

    // Default geometry of the ring.
    localparam int RING_ROWS_DEF    = 32;
    localparam int LINE_COLUMNS_DEF = 30;

    // Stream widths.
    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 2;

    // Result field widths.
    localparam int F_ROW_W  = 5;
    localparam int F_COL_W  = 5;
    localparam int F_CHAR_W = 8;
    localparam int F_LEN_W  = 5;
    localparam int F_HEAD_W = 5;
    localparam int F_CNT_W  = 6;

    // Input opcodes.
    localparam logic [1:0] OP_BEGIN = 2'd0;
    localparam logic [1:0] OP_CHAR  = 2'd1;
    localparam logic [1:0] OP_END   = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    // Result kinds.
    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_CLOSE = 2'd2;
    localparam logic [1:0] KIND_READ  = 2'd3;

    // Character constants.
    localparam logic [7:0] CHAR_USER    = 8'h55;
    localparam logic [7:0] CHAR_AGENT   = 8'h48;
    localparam logic [7:0] CHAR_COLON   = 8'h3A;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

    // Datapath events.
    typedef logic [2:0] ev_t;
    localparam ev_t EV_CLEAR = 3'd0;
    localparam ev_t EV_START = 3'd1;
    localparam ev_t EV_PUT   = 3'd2;
    localparam ev_t EV_CLOSE = 3'd3;
    localparam ev_t EV_READ  = 3'd4;

    // Source of the character written by a put event.
    typedef logic [1:0] csel_t;
    localparam csel_t CS_ITEM  = 2'd0;
    localparam csel_t CS_ROLE  = 2'd1;
    localparam csel_t CS_COLON = 2'd2;
    localparam csel_t CS_SPACE = 2'd3;

    typedef struct packed {
        logic  capture;   // latch the accepted item
        logic  plan;      // work out final head and count, read row, length read
        logic  rd_read;   // read length and store at the read row
        logic  emit;      // produce one result and apply its state update
        ev_t   ev;
        csel_t csel;
        logic  last;
    } tsr_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       wrap;      // write column is past the line end
        logic       newline;   // item character is a newline
        logic       out_free;  // result register can take a result now
    } tsr_sts_t;

endpackage

FILE: rtl/text_scrollback_line_ring.sv
// Scrollback store for a character terminal: a ring of RING_ROWS lines of
// LINE_COLUMNS characters. Each input transaction is a command (begin message,
// character, end message, or read) and yields one to four result transactions,
// the last of which carries tlast. Items are handled one at a time: after an
// item is accepted the block passes through a planning state, then emits its
// results in turn, so a begin yields four results, a character one or two (two
// when a full line wraps), an end one, and a read one, after a state that
// starts the registered read of the character and length memories. A result
// that is not taken stalls the sequence; the next item is accepted once the
// last result is in the output register. The length memory reads as zero
// until a row is written, so no clearing pass is needed after reset; character
// positions at or past a row's length always read back as zero.
`include "text_scrollback_line_ring_defines.svh"

module text_scrollback_line_ring #(
    parameter int RING_ROWS    = tsr_pkg::RING_ROWS_DEF,
    parameter int LINE_COLUMNS = tsr_pkg::LINE_COLUMNS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Command channel.
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // role [0], char_code [8:1], read_line [13:9], read_column [18:14]
    input  logic [tsr_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // opcode [1:0]
    input  logic [tsr_pkg::S_TUSER_W-1:0] s_axis_tuser,
    // Result channel.
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // row [4:0], column [9:5], out_char [17:10], line_length [22:18],
    // head_row [27:23], stored_lines [33:28], read_valid [34]
    output logic [tsr_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // kind [1:0]
    output logic [tsr_pkg::M_TUSER_W-1:0] m_axis_tuser,
    // Set on the final result of each command.
    output logic                          m_axis_tlast
);

    tsr_pkg::tsr_cmd_t cmd;
    tsr_pkg::tsr_sts_t sts;

    // The controller sequences the results of one command; the datapath owns
    // the ring state, both memories and the output register.
    tsr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tsr_datapath #(
        .RING_ROWS    (RING_ROWS),
        .LINE_COLUMNS (LINE_COLUMNS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_axis_tdata),
        .s_tuser  (s_axis_tuser),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .m_tdata  (m_axis_tdata),
        .m_tuser  (m_axis_tuser),
        .m_tlast  (m_axis_tlast)
    );

    // Only one command is in flight: acceptance closes the input until done.
    `TSR_ASSERT_NEXT(a_one_item, aclk, aresetn, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    // A new result never overwrites one that is still waiting.
    `TSR_ASSERT_SAME(a_no_overwrite, aclk, aresetn, cmd.emit && m_axis_tvalid, m_axis_tready)
    // Only read results can flag a valid read line.
    `TSR_ASSERT_SAME(a_read_flag, aclk, aresetn, m_axis_tvalid && m_axis_tdata[34], m_axis_tuser == tsr_pkg::KIND_READ)

endmodule

FILE: rtl/tsr_ram.sv
module tsr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/tsr_ctrl.sv
module tsr_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  tsr_pkg::tsr_sts_t sts,
    output tsr_pkg::tsr_cmd_t cmd
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_PLAN  = 4'd1;
    localparam logic [3:0] ST_CLEAR = 4'd2;
    localparam logic [3:0] ST_PFX0  = 4'd3;
    localparam logic [3:0] ST_PFX1  = 4'd4;
    localparam logic [3:0] ST_PFX2  = 4'd5;
    localparam logic [3:0] ST_WRAP  = 4'd6;
    localparam logic [3:0] ST_CHAR  = 4'd7;
    localparam logic [3:0] ST_NLINE = 4'd8;
    localparam logic [3:0] ST_CLOSE = 4'd9;
    localparam logic [3:0] ST_RADDR = 4'd10;
    localparam logic [3:0] ST_READ  = 4'd11;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.capture = s_tready && s_tvalid;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_PLAN;
                end
            end
            ST_PLAN: begin
                cmd.plan = 1'b1;
                case (sts.op)
                    tsr_pkg::OP_BEGIN: state_next = ST_CLEAR;
                    tsr_pkg::OP_CHAR: begin
                        if (sts.wrap) begin
                            state_next = ST_WRAP;
                        end else if (sts.newline) begin
                            state_next = ST_NLINE;
                        end else begin
                            state_next = ST_CHAR;
                        end
                    end
                    tsr_pkg::OP_END: state_next = ST_CLOSE;
                    default:         state_next = ST_RADDR;
                endcase
            end
            ST_CLEAR: begin
                cmd.ev   = tsr_pkg::EV_CLEAR;
                cmd.emit = sts.out_free;
                if (sts.out_free) begin
                    state_next = ST_PFX0;
                end
            end
            ST_PFX0: begin
                cmd.ev   = tsr_pkg::EV_PUT;
                cmd.csel = tsr_pkg::CS_ROLE;
                cmd.emit = sts.out_free;
                if (sts.out_free) begin
                    state_next = ST_PFX1;
                end
            end
            ST_PFX1: begin
                cmd.ev   = tsr_pkg::EV_PUT;
                cmd.csel = tsr_pkg::CS_COLON;
                cmd.emit = sts.out_free;
                if (sts.out_free) begin
                    state_next = ST_PFX2;
                end
            end
            ST_PFX2: begin
                cmd.ev   = tsr_pkg::EV_PUT;
                cmd.csel = tsr_pkg::CS_SPACE;
                cmd.last = 1'b1;
                cmd.emit = sts.out_free;
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_WRAP: begin
                cmd.ev   = tsr_pkg::EV_START;
                cmd.emit = sts.out_free;
                if (sts.out_free) begin
                    state_next = sts.newline ? ST_NLINE : ST_CHAR;
                end
            end
            ST_CHAR: begin
                cmd.ev   = tsr_pkg::EV_PUT;
                cmd.csel = tsr_pkg::CS_ITEM;
                cmd.last = 1'b1;
                cmd.emit = sts.out_free;
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_NLINE: begin
                cmd.ev   = tsr_pkg::EV_START;
                cmd.last = 1'b1;
                cmd.emit = sts.out_free;
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_CLOSE: begin
                cmd.ev   = tsr_pkg::EV_CLOSE;
                cmd.last = 1'b1;
                cmd.emit = sts.out_free;
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_RADDR: begin
                cmd.rd_read = 1'b1;
                state_next  = ST_READ;
            end
            ST_READ: begin
                cmd.ev   = tsr_pkg::EV_READ;
                cmd.last = 1'b1;
                cmd.emit = sts.out_free;
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/tsr_datapath.sv
module tsr_datapath #(
    parameter int RING_ROWS    = tsr_pkg::RING_ROWS_DEF,
    parameter int LINE_COLUMNS = tsr_pkg::LINE_COLUMNS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [tsr_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic [tsr_pkg::S_TUSER_W-1:0]   s_tuser,
    input  tsr_pkg::tsr_cmd_t               cmd,
    output tsr_pkg::tsr_sts_t               sts,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [tsr_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic [tsr_pkg::M_TUSER_W-1:0]   m_tuser,
    output logic                            m_tlast
);

    localparam int RW  = $clog2(RING_ROWS);
    localparam int NW  = $clog2(RING_ROWS + 1);
    localparam int CW  = $clog2(LINE_COLUMNS + 1);
    localparam int CIW = $clog2(LINE_COLUMNS);
    localparam int AW  = $clog2(RING_ROWS * LINE_COLUMNS);
    localparam int TW  = $clog2(2 * RING_ROWS + 32);

    localparam logic [RW-1:0]  ROW_LAST = RW'(RING_ROWS - 1);
    localparam logic [NW-1:0]  ROWS_N   = NW'(RING_ROWS);
    localparam logic [CW-1:0]  COLS_C   = CW'(LINE_COLUMNS);
    localparam logic [CIW-1:0] COL_LAST = CIW'(LINE_COLUMNS - 1);

    // Architectural state.
    logic [RW-1:0]        head_reg,  head_next;
    logic [NW-1:0]        count_reg, count_next;
    logic [CW-1:0]        wcol_reg,  wcol_next;
    logic [RING_ROWS-1:0] len_vld_reg, len_vld_next;

    // Item and per-item plan.
    logic [1:0]    op_reg;
    logic          role_reg;
    logic [7:0]    char_reg;
    logic [4:0]    rline_reg;
    logic [4:0]    rcol_reg;
    logic [RW-1:0] fin_head_reg;
    logic [NW-1:0] fin_count_reg;
    logic [RW-1:0] rrow_reg;
    logic          rhit_reg;
    logic          len_rvld_reg;

    // Result register.
    logic                         m_valid_reg, m_valid_next;
    logic [1:0]                   o_kind_reg,  o_kind_next;
    logic [tsr_pkg::F_ROW_W-1:0]  o_row_reg,   o_row_next;
    logic [tsr_pkg::F_COL_W-1:0]  o_col_reg,   o_col_next;
    logic [tsr_pkg::F_CHAR_W-1:0] o_char_reg,  o_char_next;
    logic [tsr_pkg::F_LEN_W-1:0]  o_len_reg,   o_len_next;
    logic                         o_rv_reg,    o_rv_next;
    logic                         o_last_reg;
    logic [tsr_pkg::F_HEAD_W-1:0] o_head_reg;
    logic [tsr_pkg::F_CNT_W-1:0]  o_cnt_reg;

    logic [RW-1:0]  head_inc, head_inc2;
    logic [NW-1:0]  count_inc, count_inc2;
    logic           wrap, newline;
    logic [1:0]     nadv;
    logic [TW-1:0]  rsum, rcnt;
    logic [RW-1:0]  rrow_calc;
    logic [CIW-1:0] put_col, rd_col;
    logic [CW-1:0]  put_len;
    logic [7:0]     put_char;
    logic [CW-1:0]  len_q;

    // Memory ports.
    logic           len_we, len_re;
    logic [RW-1:0]  len_waddr, len_raddr;
    logic [CW-1:0]  len_wdata, len_rdata;
    logic           st_we;
    logic [AW-1:0]  st_waddr, st_raddr;
    logic [7:0]     st_rdata;

    function automatic logic [RW-1:0] row_inc(input logic [RW-1:0] r);
        row_inc = (r == ROW_LAST) ? '0 : RW'(r + 1'b1);
    endfunction

    function automatic logic [NW-1:0] cnt_inc(input logic [NW-1:0] c);
        cnt_inc = (c == ROWS_N) ? c : NW'(c + 1'b1);
    endfunction

    assign head_inc   = row_inc(head_reg);
    assign head_inc2  = row_inc(head_inc);
    assign count_inc  = cnt_inc(count_reg);
    assign count_inc2 = cnt_inc(count_inc);

    assign wrap    = (wcol_reg >= COLS_C);
    assign newline = (char_reg == tsr_pkg::CHAR_NEWLINE);

    always_comb begin
        case (op_reg)
            tsr_pkg::OP_CHAR: nadv = {1'b0, wrap} + {1'b0, newline};
            tsr_pkg::OP_END:  nadv = 2'd1;
            default:          nadv = 2'd0;
        endcase
    end

    // Physical row of a read: oldest row plus line age, modulo the row count.
    assign rsum      = TW'(head_reg) + TW'(rline_reg);
    assign rcnt      = TW'(count_reg);
    assign rrow_calc = (rsum >= rcnt) ? RW'(rsum - rcnt)
                                      : RW'(rsum + TW'(RING_ROWS) - rcnt);

    assign put_col = wrap ? COL_LAST : wcol_reg[CIW-1:0];
    assign put_len = CW'(put_col) + CW'(1);
    assign rd_col  = (int'(rcol_reg) >= LINE_COLUMNS) ? COL_LAST : CIW'(rcol_reg);

    always_comb begin
        case (cmd.csel)
            tsr_pkg::CS_ROLE:  put_char = role_reg ? tsr_pkg::CHAR_USER : tsr_pkg::CHAR_AGENT;
            tsr_pkg::CS_COLON: put_char = tsr_pkg::CHAR_COLON;
            tsr_pkg::CS_SPACE: put_char = tsr_pkg::CHAR_SPACE;
            default:           put_char = char_reg;
        endcase
    end

    // A length entry never written since reset reads as zero.
    assign len_q = len_rvld_reg ? len_rdata : '0;

    assign sts.op       = op_reg;
    assign sts.wrap     = wrap;
    assign sts.newline  = newline;
    assign sts.out_free = !m_valid_reg || m_tready;

    assign len_re    = cmd.plan || cmd.rd_read;
    assign len_raddr = cmd.rd_read ? rrow_reg : head_reg;
    assign st_raddr  = AW'(rrow_reg * LINE_COLUMNS) + AW'(rd_col);
    assign st_waddr  = AW'(head_reg * LINE_COLUMNS) + AW'(put_col);
    assign st_we     = cmd.emit && (cmd.ev == tsr_pkg::EV_PUT);

    always_comb begin
        head_next    = head_reg;
        count_next   = count_reg;
        wcol_next    = wcol_reg;
        len_vld_next = len_vld_reg;
        len_we       = 1'b0;
        len_waddr    = head_reg;
        len_wdata    = '0;
        m_valid_next = m_valid_reg && !m_tready;
        o_kind_next  = o_kind_reg;
        o_row_next   = o_row_reg;
        o_col_next   = o_col_reg;
        o_char_next  = o_char_reg;
        o_len_next   = o_len_reg;
        o_rv_next    = o_rv_reg;
        if (cmd.emit) begin
            m_valid_next = 1'b1;
            o_row_next   = tsr_pkg::F_ROW_W'(head_reg);
            o_col_next   = '0;
            o_char_next  = '0;
            o_len_next   = '0;
            o_rv_next    = 1'b0;
            case (cmd.ev)
                tsr_pkg::EV_CLEAR: begin
                    o_kind_next = tsr_pkg::KIND_START;
                    len_we      = 1'b1;
                    wcol_next   = '0;
                end
                tsr_pkg::EV_START: begin
                    o_kind_next = tsr_pkg::KIND_START;
                    o_row_next  = tsr_pkg::F_ROW_W'(head_inc);
                    head_next   = head_inc;
                    count_next  = count_inc;
                    len_we      = 1'b1;
                    len_waddr   = head_inc;
                    wcol_next   = '0;
                end
                tsr_pkg::EV_PUT: begin
                    o_kind_next = tsr_pkg::KIND_WRITE;
                    o_col_next  = tsr_pkg::F_COL_W'(put_col);
                    o_char_next = put_char;
                    o_len_next  = tsr_pkg::F_LEN_W'(put_len);
                    len_we      = 1'b1;
                    len_wdata   = put_len;
                    wcol_next   = put_len;
                end
                tsr_pkg::EV_CLOSE: begin
                    o_kind_next = tsr_pkg::KIND_CLOSE;
                    o_len_next  = tsr_pkg::F_LEN_W'(len_q);
                    head_next   = head_inc;
                    count_next  = count_inc;
                    wcol_next   = '0;
                end
                default: begin
                    // A read outside the stored lines reports row zero.
                    o_kind_next = tsr_pkg::KIND_READ;
                    o_row_next  = '0;
                    o_col_next  = rcol_reg;
                    o_rv_next   = rhit_reg;
                    if (rhit_reg) begin
                        o_row_next = tsr_pkg::F_ROW_W'(rrow_reg);
                        o_len_next = tsr_pkg::F_LEN_W'(len_q);
                        if (int'(rcol_reg) < int'(len_q)) begin
                            o_char_next = st_rdata;
                        end
                    end
                end
            endcase
            if (len_we) begin
                len_vld_next[len_waddr] = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= '0;
            count_reg   <= '0;
            wcol_reg    <= '0;
            len_vld_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            head_reg    <= head_next;
            count_reg   <= count_next;
            wcol_reg    <= wcol_next;
            len_vld_reg <= len_vld_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg    <= s_tuser[1:0];
            role_reg  <= s_tdata[0];
            char_reg  <= s_tdata[8:1];
            rline_reg <= s_tdata[13:9];
            rcol_reg  <= s_tdata[18:14];
        end
        if (cmd.plan) begin
            rrow_reg <= rrow_calc;
            rhit_reg <= (TW'(rline_reg) < rcnt);
            case (nadv)
                2'd0: begin
                    fin_head_reg  <= head_reg;
                    fin_count_reg <= count_reg;
                end
                2'd1: begin
                    fin_head_reg  <= head_inc;
                    fin_count_reg <= count_inc;
                end
                default: begin
                    fin_head_reg  <= head_inc2;
                    fin_count_reg <= count_inc2;
                end
            endcase
        end
        if (len_re) begin
            len_rvld_reg <= len_vld_reg[len_raddr];
        end
        // The item totals travel with each result, so a result still waiting
        // keeps them while the next item is planned.
        if (cmd.emit) begin
            o_last_reg <= cmd.last;
            o_head_reg <= tsr_pkg::F_HEAD_W'(fin_head_reg);
            o_cnt_reg  <= tsr_pkg::F_CNT_W'(fin_count_reg);
        end
        o_kind_reg <= o_kind_next;
        o_row_reg  <= o_row_next;
        o_col_reg  <= o_col_next;
        o_char_reg <= o_char_next;
        o_len_reg  <= o_len_next;
        o_rv_reg   <= o_rv_next;
    end

    tsr_ram #(
        .WIDTH (CW),
        .DEPTH (RING_ROWS)
    ) u_len_ram (
        .aclk  (aclk),
        .we    (len_we),
        .waddr (len_waddr),
        .wdata (len_wdata),
        .re    (len_re),
        .raddr (len_raddr),
        .rdata (len_rdata)
    );

    tsr_ram #(
        .WIDTH (8),
        .DEPTH (RING_ROWS * LINE_COLUMNS)
    ) u_store_ram (
        .aclk  (aclk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (put_char),
        .re    (cmd.rd_read),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = o_kind_reg;
    assign m_tlast  = o_last_reg;
    assign m_tdata  = {5'b0,
                       o_rv_reg,
                       o_cnt_reg,
                       o_head_reg,
                       o_len_reg,
                       o_char_reg,
                       o_col_reg,
                       o_row_reg};

endmodule
